FILE: design/nv12d_pkg.sv
package nv12d_pkg;

  // tile geometry
  localparam int TILE_WIDTH  = 64;
  localparam int TILE_HEIGHT = 32;
  localparam int TILE_BYTES  = TILE_WIDTH * TILE_HEIGHT;
  localparam int HALF_TILE   = TILE_BYTES / 2;
  localparam int COL_SHIFT   = $clog2(TILE_WIDTH);
  localparam int ROW_SHIFT   = $clog2(TILE_HEIGHT);
  localparam int TILE_SHIFT  = $clog2(TILE_BYTES);

  // field widths
  localparam int COL_W     = 7;
  localparam int ROW_W     = 8;
  localparam int STRIDE_W  = 14;
  localparam int HEIGHT_W  = 14;
  localparam int TA_W      = 8;
  localparam int LTR_W     = 9;
  localparam int CTR_W     = 8;
  localparam int CSO_W     = 27;
  localparam int SRC_W     = 27;
  localparam int DST_W     = 26;
  localparam int LEN_W     = 7;
  localparam int LINES_W   = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 27;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DST_STRIDE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TILES_ACROSS      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LUMA_TILE_ROWS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_TILE_ROWS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CHROMA_SRC_OFFSET = 3'd5;

  // plane codes
  localparam logic PLANE_LUMA   = 1'b0;
  localparam logic PLANE_CHROMA = 1'b1;

  typedef struct packed {
    logic capture;
    logic finish;
    logic emit;
    logic plane;
    logic last;
  } dp_cmd_t;

  typedef struct packed {
    logic               empty;
    logic [LINES_W-1:0] lines;
  } dp_sts_t;

endpackage

FILE: design/nv12d_ifs.sv
interface nv12d_in_if;
  logic                           valid;
  logic                           ready;
  logic [nv12d_pkg::COL_W-1:0]    block_col;
  logic [nv12d_pkg::ROW_W-1:0]    block_row;
  modport source (output valid, block_col, block_row, input ready);
  modport sink   (input valid, block_col, block_row, output ready);
endinterface

interface nv12d_out_if;
  logic                           valid;
  logic                           ready;
  logic                           dst_plane;
  logic [nv12d_pkg::SRC_W-1:0]    src_offset;
  logic [nv12d_pkg::DST_W-1:0]    dst_offset;
  logic [nv12d_pkg::LEN_W-1:0]    copy_length;
  logic                           last_line;
  modport source (output valid, dst_plane, src_offset, dst_offset, copy_length, last_line,
                  input ready);
  modport sink   (input valid, dst_plane, src_offset, dst_offset, copy_length, last_line,
                  output ready);
endinterface

interface nv12d_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nv12d_pkg::CFG_IDX_W-1:0]   index;
  logic [nv12d_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: design/nv12_tile_detile_address_gen.sv
// line-copy command generator for a 64x32 zig-zag tiled nv12 source. each request names
// one destination block (64 bytes wide, 32 luma lines tall) and is answered with the copy
// commands for its luma lines and matching interleaved chroma lines, ordered as two luma
// lines then one chroma line, with last_line set on the final command. a block with L
// lines (L = min(32, frame_height - 32*row)) gives L + ceil(L/2) commands, at most 48.
// timing: a request is taken only while the block is idle; two setup steps follow
// (multipliers for tile row and destination row, then tile index and start pointers),
// then one command per cycle from the output register while the sink keeps up; a block
// outside the stride or frame gives no commands. configuration writes are always
// accepted and must only be made while the block is idle.
module nv12_tile_detile_address_gen (
  input  logic             clk,
  input  logic             rst_n,
  nv12d_in_if.sink         in_ch,
  nv12d_out_if.source      out_ch,
  nv12d_cfg_if.sink        cfg_ch
);

  nv12d_pkg::dp_cmd_t cmd;
  nv12d_pkg::dp_sts_t sts;

  // register writes never stall
  assign cfg_ch.ready = 1'b1;

  // sequencer: request intake, setup steps and luma/chroma command order
  nv12d_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // datapath: config registers, tile address arithmetic, pointers, output register
  nv12d_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_block_col    (in_ch.block_col),
    .in_block_row    (in_ch.block_row),
    .cfg_valid       (cfg_ch.valid),
    .cfg_index       (cfg_ch.index),
    .cfg_data        (cfg_ch.data),
    .out_dst_plane   (out_ch.dst_plane),
    .out_src_offset  (out_ch.src_offset),
    .out_dst_offset  (out_ch.dst_offset),
    .out_copy_length (out_ch.copy_length),
    .out_last_line   (out_ch.last_line)
  );

endmodule

FILE: design/nv12d_ctrl.sv
module nv12d_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output nv12d_pkg::dp_cmd_t   cmd,
  input  nv12d_pkg::dp_sts_t   sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CALC = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  localparam logic [1:0] PH_LUMA_A = 2'd0;
  localparam logic [1:0] PH_LUMA_B = 2'd1;
  localparam logic [1:0] PH_CHROMA = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [1:0]                    phase_r, phase_nxt;
  logic [nv12d_pkg::LINES_W-1:0] left_r, left_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_CALC;
        end
      end
      S_CALC: begin
        cmd.finish = 1'b1;
        if (sts.empty) begin
          state_nxt = S_IDLE;
        end else begin
          left_nxt  = sts.lines;
          phase_nxt = PH_LUMA_A;
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit = 1'b1;
          unique case (phase_r)
            PH_LUMA_A: begin
              cmd.plane = nv12d_pkg::PLANE_LUMA;
              left_nxt  = left_r - 1'b1;
              phase_nxt = (left_r > 1) ? PH_LUMA_B : PH_CHROMA;
            end
            PH_LUMA_B: begin
              cmd.plane = nv12d_pkg::PLANE_LUMA;
              left_nxt  = left_r - 1'b1;
              phase_nxt = PH_CHROMA;
            end
            PH_CHROMA: begin
              cmd.plane = nv12d_pkg::PLANE_CHROMA;
              cmd.last  = (left_r == '0);
              phase_nxt = PH_LUMA_A;
              if (left_r == '0) begin
                state_nxt = S_IDLE;
              end
            end
            default: begin
              phase_nxt = PH_LUMA_A;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_LUMA_A;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: design/nv12d_dp.sv
module nv12d_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  nv12d_pkg::dp_cmd_t                  cmd,
  output nv12d_pkg::dp_sts_t                  sts,
  input  logic [nv12d_pkg::COL_W-1:0]         in_block_col,
  input  logic [nv12d_pkg::ROW_W-1:0]         in_block_row,
  input  logic                                cfg_valid,
  input  logic [nv12d_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [nv12d_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                out_dst_plane,
  output logic [nv12d_pkg::SRC_W-1:0]         out_src_offset,
  output logic [nv12d_pkg::DST_W-1:0]         out_dst_offset,
  output logic [nv12d_pkg::LEN_W-1:0]         out_copy_length,
  output logic                                out_last_line
);

  localparam int COL_W    = nv12d_pkg::COL_W;
  localparam int ROW_W    = nv12d_pkg::ROW_W;
  localparam int STRIDE_W = nv12d_pkg::STRIDE_W;
  localparam int HEIGHT_W = nv12d_pkg::HEIGHT_W;
  localparam int SRC_W    = nv12d_pkg::SRC_W;
  localparam int DST_W    = nv12d_pkg::DST_W;
  localparam int LEN_W    = nv12d_pkg::LEN_W;
  localparam int LINES_W  = nv12d_pkg::LINES_W;
  localparam int PROD_W   = ROW_W + nv12d_pkg::TA_W;
  localparam int RS_W     = ROW_W + STRIDE_W;
  localparam int IDX_W    = PROD_W + 1;

  // configuration registers
  logic [STRIDE_W-1:0]             stride_r;
  logic [HEIGHT_W-1:0]             height_r;
  logic [nv12d_pkg::TA_W-1:0]      ta_r;
  logic [nv12d_pkg::LTR_W-1:0]     luma_rows_r;
  logic [nv12d_pkg::CTR_W-1:0]     chroma_rows_r;
  logic [nv12d_pkg::CSO_W-1:0]     cso_r;

  // setup stage
  logic [COL_W-1:0]   col_r;
  logic [ROW_W-1:0]   row_r;
  logic [PROD_W-1:0]  yprod_r, cprod_r;
  logic [RS_W-1:0]    rs_r;
  logic [LEN_W-1:0]   len_r;
  logic [LINES_W-1:0] lines_r;
  logic               empty_r;

  // running pointers
  logic [SRC_W-1:0]   ysrc_r, csrc_r;
  logic [DST_W-1:0]   ydst_r, cdst_r;

  // output register
  logic               out_plane_r, out_last_r;
  logic [SRC_W-1:0]   out_src_r;
  logic [DST_W-1:0]   out_dst_r;
  logic [LEN_W-1:0]   out_len_r;

  logic [STRIDE_W-1:0] xoff_w, len_diff_w;
  logic [HEIGHT_W-1:0] yoff_w, lines_diff_w;
  logic [ROW_W-1:0]    yrow_pair_w, crow_pair_w;
  logic [IDX_W-1:0]    yidx_w, cidx_w;
  logic [ROW_W-2:0]    crow_w;
  logic                yfinal_w, cfinal_w;
  logic [DST_W-1:0]    xoff_dst_w;

  // zig-zag placement within a tile row pair
  function automatic logic [IDX_W-1:0] tile_adj(input logic [COL_W-1:0] x,
                                                input logic y_odd,
                                                input logic final_row);
    logic [COL_W:0] x2;
    begin
      x2 = {1'b0, x} + (COL_W+1)'(2);
      if (y_odd) begin
        tile_adj = IDX_W'({x[COL_W-1:2], 2'b00}) + IDX_W'(2);
      end else if (final_row) begin
        tile_adj = '0;
      end else begin
        tile_adj = IDX_W'({x2[COL_W:2], 2'b00});
      end
    end
  endfunction

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r      <= STRIDE_W'(nv12d_pkg::TILE_WIDTH);
      height_r      <= HEIGHT_W'(nv12d_pkg::TILE_HEIGHT);
      ta_r          <= nv12d_pkg::TA_W'(1);
      luma_rows_r   <= nv12d_pkg::LTR_W'(1);
      chroma_rows_r <= nv12d_pkg::CTR_W'(1);
      cso_r         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        nv12d_pkg::CFG_DST_STRIDE:        stride_r      <= cfg_data[STRIDE_W-1:0];
        nv12d_pkg::CFG_FRAME_HEIGHT:      height_r      <= cfg_data[HEIGHT_W-1:0];
        nv12d_pkg::CFG_TILES_ACROSS:      ta_r          <= cfg_data[nv12d_pkg::TA_W-1:0];
        nv12d_pkg::CFG_LUMA_TILE_ROWS:    luma_rows_r   <= cfg_data[nv12d_pkg::LTR_W-1:0];
        nv12d_pkg::CFG_CHROMA_TILE_ROWS:  chroma_rows_r <= cfg_data[nv12d_pkg::CTR_W-1:0];
        nv12d_pkg::CFG_CHROMA_SRC_OFFSET: cso_r         <= cfg_data[nv12d_pkg::CSO_W-1:0];
        default: ;
      endcase
    end
  end

  // setup stage: extents and products from the request fields
  assign xoff_w       = STRIDE_W'(in_block_col) << nv12d_pkg::COL_SHIFT;
  assign yoff_w       = HEIGHT_W'(in_block_row) << nv12d_pkg::ROW_SHIFT;
  assign len_diff_w   = stride_r - xoff_w;
  assign lines_diff_w = height_r - yoff_w;
  assign yrow_pair_w  = {in_block_row[ROW_W-1:1], 1'b0};
  assign crow_pair_w  = {1'b0, in_block_row[ROW_W-1:2], 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      col_r   <= in_block_col;
      row_r   <= in_block_row;
      yprod_r <= PROD_W'(yrow_pair_w) * PROD_W'(ta_r);
      cprod_r <= PROD_W'(crow_pair_w) * PROD_W'(ta_r);
      rs_r    <= RS_W'(in_block_row) * RS_W'(stride_r);
      empty_r <= (xoff_w >= stride_r) || (yoff_w >= height_r);
      len_r   <= (len_diff_w > STRIDE_W'(nv12d_pkg::TILE_WIDTH))
                 ? LEN_W'(nv12d_pkg::TILE_WIDTH) : len_diff_w[LEN_W-1:0];
      lines_r <= (lines_diff_w > HEIGHT_W'(nv12d_pkg::TILE_HEIGHT))
                 ? LINES_W'(nv12d_pkg::TILE_HEIGHT) : lines_diff_w[LINES_W-1:0];
    end
  end

  assign sts.empty = empty_r;
  assign sts.lines = lines_r;

  // address stage: tile indexes and start pointers
  assign crow_w     = row_r[ROW_W-1:1];
  assign yfinal_w   = luma_rows_r[0] &&
                      (nv12d_pkg::LTR_W'(row_r) == luma_rows_r - 1'b1);
  assign cfinal_w   = chroma_rows_r[0] &&
                      (nv12d_pkg::CTR_W'(crow_w) == chroma_rows_r - 1'b1);
  assign yidx_w     = IDX_W'(col_r) + IDX_W'(yprod_r) + tile_adj(col_r, row_r[0], yfinal_w);
  assign cidx_w     = IDX_W'(col_r) + IDX_W'(cprod_r) + tile_adj(col_r, row_r[1], cfinal_w);
  assign xoff_dst_w = DST_W'(col_r) << nv12d_pkg::COL_SHIFT;

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      ysrc_r <= SRC_W'(yidx_w) << nv12d_pkg::TILE_SHIFT;
      csrc_r <= cso_r + (SRC_W'(cidx_w) << nv12d_pkg::TILE_SHIFT)
                + (row_r[0] ? SRC_W'(nv12d_pkg::HALF_TILE) : '0);
      ydst_r <= (DST_W'(rs_r) << nv12d_pkg::ROW_SHIFT) + xoff_dst_w;
      cdst_r <= (DST_W'(rs_r) << (nv12d_pkg::ROW_SHIFT - 1)) + xoff_dst_w;
    end else if (cmd.emit) begin
      if (cmd.plane == nv12d_pkg::PLANE_CHROMA) begin
        csrc_r <= csrc_r + SRC_W'(nv12d_pkg::TILE_WIDTH);
        cdst_r <= cdst_r + DST_W'(stride_r);
      end else begin
        ysrc_r <= ysrc_r + SRC_W'(nv12d_pkg::TILE_WIDTH);
        ydst_r <= ydst_r + DST_W'(stride_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_plane_r <= cmd.plane;
      out_last_r  <= cmd.last;
      out_len_r   <= len_r;
      out_src_r   <= (cmd.plane == nv12d_pkg::PLANE_CHROMA) ? csrc_r : ysrc_r;
      out_dst_r   <= (cmd.plane == nv12d_pkg::PLANE_CHROMA) ? cdst_r : ydst_r;
    end
  end

  assign out_dst_plane   = out_plane_r;
  assign out_src_offset  = out_src_r;
  assign out_dst_offset  = out_dst_r;
  assign out_copy_length = out_len_r;
  assign out_last_line   = out_last_r;

endmodule
